// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hdl/lsp_pkg.sv -----
package lsp_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;

   localparam int MODE_W  = 3;
   localparam int POS_W   = 5;
   localparam int CAP_W   = 5;
   localparam int OUT_W   = 32;
   localparam int STAT_W  = 2;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int PADDR_W = 2;
   localparam int PDATA_W = 32;

   localparam logic [CAP_W-1:0]   CAP_RESET    = CAP_W'(16);
   localparam logic [PADDR_W-1:0] ADDR_CAPACITY = PADDR_W'(0);

   localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TOP    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BOTTOM = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

   typedef logic [DATA_WIDTH-1:0] word_type;

   typedef struct packed {
      logic push;
      logic pop;
   } shift_type;

   // Keeps the low DATA_WIDTH bits of a pushed word.
   function automatic word_type to_word(input logic [OUT_W-1:0] v);
      word_type w;
      w = '0;
      for (int i = 0; i < DATA_WIDTH; i++) begin
         if (i < OUT_W) begin
            w[i] = v[i % OUT_W];
         end
      end
      return w;
   endfunction

   // Sign-extends a stored word to the result width.
   function automatic logic [OUT_W-1:0] widen(input word_type w);
      logic [OUT_W-1:0] o;
      o = '0;
      for (int i = 0; i < OUT_W; i++) begin
         if (i < DATA_WIDTH) begin
            o[i] = w[i % DATA_WIDTH];
         end else begin
            o[i] = w[DATA_WIDTH-1];
         end
      end
      return o;
   endfunction

endpackage

// ----- hdl/lifo_stack_with_peek_top.sv -----
// LIFO stack of signed words held in a row of shift cells, with the top word
// always in the first cell. A push moves every word one cell down and a pop
// moves every word one cell up, and a new request can be accepted in every
// cycle in which req_ready is high. The result is registered and shows in
// the cycle after its request transfer; req_ready stays high while the
// result register is empty or its result is being taken. A peek selects the
// addressed cell by a per-cell compare, and the oldest word is also kept in a
// register of its own for bottom reads. The capacity register may only be
// written while no request is in flight.
module lifo_stack_with_peek_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lsp_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [lsp_pkg::OUT_W-1:0]    req_push_value,
   input  logic [lsp_pkg::POS_W-1:0]           req_position,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [lsp_pkg::OUT_W-1:0]    rsp_data,
   output logic [lsp_pkg::STAT_W-1:0]          rsp_status,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lsp_pkg::PADDR_W-1:0]         csr_paddr,
   input  logic [lsp_pkg::PDATA_W-1:0]         csr_pwdata,
   output logic [lsp_pkg::PDATA_W-1:0]         csr_prdata,
   output logic                                csr_pready
);

   logic [lsp_pkg::CAP_W-1:0]  capacity_ff, capacity_in;
   logic [lsp_pkg::CNT_W-1:0]  fill_ff, fill_in;
   lsp_pkg::word_type          bottom_ff, bottom_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [lsp_pkg::OUT_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [lsp_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;

   lsp_pkg::shift_type         shift;
   lsp_pkg::word_type          push_word;
   lsp_pkg::word_type          peek_word;
   lsp_pkg::word_type          cell_word [lsp_pkg::DEPTH];
   lsp_pkg::word_type          peek_part [lsp_pkg::DEPTH];
   logic [lsp_pkg::DEPTH-1:0]  peek_sel;

   logic                       accept;
   logic                       csr_write;
   logic [lsp_pkg::CMP_W-1:0]  cap_wide;
   logic [lsp_pkg::CMP_W-1:0]  cap_eff;
   logic [lsp_pkg::CMP_W-1:0]  fill_wide;
   logic [lsp_pkg::CMP_W-1:0]  pos_wide;
   logic                       is_full;
   logic                       is_empty;
   logic                       peek_ok;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign push_word = lsp_pkg::to_word(req_push_value);

   // Row of cells: cell 0 holds the top of the stack.
   for (genvar g = 0; g < lsp_pkg::DEPTH; g++) begin : g_cell
      lsp_pkg::word_type above;
      lsp_pkg::word_type below;

      if (g == 0) begin : g_first
         assign above = push_word;
      end else begin : g_inner
         assign above = cell_word[g-1];
      end

      if (g == lsp_pkg::DEPTH - 1) begin : g_last
         assign below = '0;
      end else begin : g_mid
         assign below = cell_word[g+1];
      end

      assign peek_sel[g] = (pos_wide == lsp_pkg::CMP_W'(g + 1));

      lsp_cell u_cell (
         .clock      (clock),
         .shift      (shift),
         .from_above (above),
         .from_below (below),
         .peek_sel   (peek_sel[g]),
         .word       (cell_word[g]),
         .peek_word  (peek_part[g])
      );
   end

   always_comb begin
      peek_word = '0;
      for (int i = 0; i < lsp_pkg::DEPTH; i++) begin
         peek_word = peek_word | peek_part[i];
      end
   end

   assign cap_wide  = lsp_pkg::CMP_W'(capacity_ff);
   assign fill_wide = lsp_pkg::CMP_W'(fill_ff);
   assign pos_wide  = lsp_pkg::CMP_W'(req_position);

   always_comb begin
      priority if (capacity_ff == '0) begin
         cap_eff = lsp_pkg::CMP_W'(1);
      end else if (cap_wide > lsp_pkg::CMP_W'(lsp_pkg::DEPTH)) begin
         cap_eff = lsp_pkg::CMP_W'(lsp_pkg::DEPTH);
      end else begin
         cap_eff = cap_wide;
      end
   end

   assign is_full  = (fill_wide >= cap_eff) ||
                     (fill_wide >= lsp_pkg::CMP_W'(lsp_pkg::DEPTH));
   assign is_empty = (fill_ff == '0);
   assign peek_ok  = (req_position != '0) && (pos_wide <= fill_wide);

   always_comb begin
      shift         = '0;
      fill_in       = fill_ff;
      bottom_in     = bottom_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = '0;
         rsp_status_in = lsp_pkg::ST_OK;
         unique case (req_mode)
            lsp_pkg::MODE_PUSH: begin
               if (is_full) begin
                  rsp_status_in = lsp_pkg::ST_FULL;
               end else begin
                  shift.push = 1'b1;
                  fill_in    = fill_ff + lsp_pkg::CNT_W'(1);
                  if (is_empty) begin
                     bottom_in = push_word;
                  end
               end
            end
            lsp_pkg::MODE_POP: begin
               if (is_empty) begin
                  rsp_data_in   = '1;
                  rsp_status_in = lsp_pkg::ST_EMPTY;
               end else begin
                  shift.pop   = 1'b1;
                  fill_in     = fill_ff - lsp_pkg::CNT_W'(1);
                  rsp_data_in = lsp_pkg::widen(cell_word[0]);
               end
            end
            lsp_pkg::MODE_PEEK: begin
               if (peek_ok) begin
                  rsp_data_in = lsp_pkg::widen(peek_word);
               end else begin
                  rsp_status_in = lsp_pkg::ST_BADPOS;
               end
            end
            lsp_pkg::MODE_TOP: begin
               if (is_empty) begin
                  rsp_status_in = lsp_pkg::ST_EMPTY;
               end else begin
                  rsp_data_in = lsp_pkg::widen(cell_word[0]);
               end
            end
            lsp_pkg::MODE_BOTTOM: begin
               if (is_empty) begin
                  rsp_status_in = lsp_pkg::ST_EMPTY;
               end else begin
                  rsp_data_in = lsp_pkg::widen(bottom_ff);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign csr_write   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign capacity_in = (csr_write && (csr_paddr == lsp_pkg::ADDR_CAPACITY)) ?
                        csr_pwdata[lsp_pkg::CAP_W-1:0] : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= lsp_pkg::CAP_RESET;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bottom_ff     <= bottom_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == lsp_pkg::ADDR_CAPACITY) ?
                       lsp_pkg::PDATA_W'(capacity_ff) : '0;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ----- hdl/lsp_cell.sv -----
module lsp_cell (
   input  logic              clock,
   input  lsp_pkg::shift_type shift,
   input  lsp_pkg::word_type  from_above,
   input  lsp_pkg::word_type  from_below,
   input  logic              peek_sel,
   output lsp_pkg::word_type  word,
   output lsp_pkg::word_type  peek_word
);

   lsp_pkg::word_type word_ff;
   lsp_pkg::word_type word_in;

   always_comb begin
      priority if (shift.push) begin
         word_in = from_above;
      end else if (shift.pop) begin
         word_in = from_below;
      end else begin
         word_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word      = word_ff;
   assign peek_word = peek_sel ? word_ff : '0;

endmodule

// ----- hdl/lsp_checker.sv -----
`include "assert_macros.svh"

module lsp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [lsp_pkg::OUT_W-1:0]  rsp_data,
   input logic [lsp_pkg::STAT_W-1:0]        rsp_status
);

   logic rsp_no_word;

   assign rsp_no_word = (rsp_status == lsp_pkg::ST_FULL) ||
                        (rsp_status == lsp_pkg::ST_BADPOS);

   // No result is offered right after reset.
   `ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

   // Every accepted request produces a result in the next cycle.
   `ASSERT_NEXT(a_result_follows, clock, reset, req_valid && req_ready, rsp_valid)

   // A dropped push or a bad peek carries no word.
   `ASSERT_SAME(a_fail_zero, clock, reset, rsp_valid && rsp_no_word, rsp_data == '0)

   // A stalled result stays offered with the same payload.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data) && $stable(rsp_status))

endmodule

bind lifo_stack_with_peek_top lsp_checker u_lsp_checker (.*);

// ----- tb/tb_lifo_stack_with_peek_top.sv -----
module tb_lifo_stack_with_peek_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [lsp_pkg::MODE_W-1:0] MODE_SPARE_LO = lsp_pkg::MODE_BOTTOM + 3'd1;
   localparam logic [lsp_pkg::MODE_W-1:0] MODE_SPARE_HI = '1;
   localparam logic [lsp_pkg::OUT_W-1:0]  WORD_MIN      = {1'b1, {(lsp_pkg::OUT_W-1){1'b0}}};
   localparam logic [lsp_pkg::OUT_W-1:0]  WORD_MAX      = {1'b0, {(lsp_pkg::OUT_W-1){1'b1}}};
   localparam logic [lsp_pkg::OUT_W-1:0]  WORD_ALL_ONES = '1;
   localparam int                         HOLD_CYCLES   = 160;

   typedef struct packed {
      logic [lsp_pkg::OUT_W-1:0]  data;
      logic [lsp_pkg::STAT_W-1:0] status;
   } stack_result_type;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [lsp_pkg::MODE_W-1:0]        req_mode;
   logic signed [lsp_pkg::OUT_W-1:0]  req_push_value;
   logic [lsp_pkg::POS_W-1:0]         req_position;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic signed [lsp_pkg::OUT_W-1:0]  rsp_data;
   logic [lsp_pkg::STAT_W-1:0]        rsp_status;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [lsp_pkg::PADDR_W-1:0]       csr_paddr;
   logic [lsp_pkg::PDATA_W-1:0]       csr_pwdata;
   logic [lsp_pkg::PDATA_W-1:0]       csr_prdata;
   logic                              csr_pready;

   logic [lsp_pkg::OUT_W-1:0]  stack_words [lsp_pkg::DEPTH];
   int                         stack_fill;
   logic [lsp_pkg::CAP_W-1:0]  cap_setting;
   stack_result_type           pending_results [$];
   int                         mismatches;
   bit                         sender_gaps;
   bit                         receiver_gaps;
   int                         hold_requests;
   int                         hold_seen;
   int                         hold_left;
   int                         stall_left;

   lifo_stack_with_peek_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_push_value (req_push_value),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .rsp_status     (rsp_status),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   function automatic int effective_capacity();
      if (cap_setting == '0) begin
         return 1;
      end
      if (cap_setting > lsp_pkg::DEPTH) begin
         return lsp_pkg::DEPTH;
      end
      return int'(cap_setting);
   endfunction

   // Applies one request to the stack image and returns the result it gives.
   function automatic stack_result_type stack_apply(
         input logic [lsp_pkg::MODE_W-1:0] mode,
         input logic [lsp_pkg::OUT_W-1:0] value,
         input logic [lsp_pkg::POS_W-1:0] pos);
      stack_result_type r;
      r.data   = '0;
      r.status = lsp_pkg::ST_OK;
      case (mode)
         lsp_pkg::MODE_PUSH: begin
            if (stack_fill >= effective_capacity()) begin
               r.status = lsp_pkg::ST_FULL;
            end else begin
               stack_words[stack_fill] = value;
               stack_fill++;
            end
         end
         lsp_pkg::MODE_POP: begin
            if (stack_fill == 0) begin
               r.data   = WORD_ALL_ONES;
               r.status = lsp_pkg::ST_EMPTY;
            end else begin
               stack_fill--;
               r.data = stack_words[stack_fill];
            end
         end
         lsp_pkg::MODE_PEEK: begin
            if (pos == '0 || int'(pos) > stack_fill) begin
               r.status = lsp_pkg::ST_BADPOS;
            end else begin
               r.data = stack_words[stack_fill - int'(pos)];
            end
         end
         lsp_pkg::MODE_TOP: begin
            if (stack_fill == 0) begin
               r.status = lsp_pkg::ST_EMPTY;
            end else begin
               r.data = stack_words[stack_fill - 1];
            end
         end
         lsp_pkg::MODE_BOTTOM: begin
            if (stack_fill == 0) begin
               r.status = lsp_pkg::ST_EMPTY;
            end else begin
               r.data = stack_words[0];
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Predicts each accepted request, then checks each accepted result.
   always @(posedge clock) begin
      stack_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pending_results.push_back(stack_apply(req_mode, req_push_value, req_position));
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result data %h status %0d",
                                         rsp_data, rsp_status));
            end else begin
               want = pending_results.pop_front();
               if (rsp_data !== want.data) begin
                  report_mismatch($sformatf("data %h, expected %h", rsp_data, want.data));
               end
               if (rsp_status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_item(input logic [lsp_pkg::MODE_W-1:0] mode,
                            input logic [lsp_pkg::OUT_W-1:0] value,
                            input logic [lsp_pkg::POS_W-1:0] pos);
      if (sender_gaps && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_push_value <= value;
      req_position   <= pos;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [lsp_pkg::PDATA_W-1:0] value);
      logic [lsp_pkg::PDATA_W-1:0] readback;
      wait_for_results();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= lsp_pkg::ADDR_CAPACITY;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      cap_setting = value[lsp_pkg::CAP_W-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== lsp_pkg::PDATA_W'(cap_setting)) begin
         report_mismatch($sformatf("capacity reads %h, expected %h", readback, cap_setting));
      end
   endtask

   task automatic send_random_item(input int push_weight);
      int                        pick;
      logic [lsp_pkg::POS_W-1:0] pos;
      pick = $urandom_range(0, 99);
      pos  = $urandom_range(0, 2) == 0 ?
             lsp_pkg::POS_W'($urandom()) :
             lsp_pkg::POS_W'($urandom_range(1, stack_fill + 1));
      if (pick < push_weight) begin
         send_item(lsp_pkg::MODE_PUSH, $urandom(), lsp_pkg::POS_W'($urandom()));
      end else if (pick < push_weight + 25) begin
         send_item(lsp_pkg::MODE_POP, $urandom(), lsp_pkg::POS_W'($urandom()));
      end else if (pick < push_weight + 45) begin
         send_item(lsp_pkg::MODE_PEEK, $urandom(), pos);
      end else if (pick < 97) begin
         send_item(pick[0] ? lsp_pkg::MODE_TOP : lsp_pkg::MODE_BOTTOM, $urandom(), pos);
      end else begin
         send_item(lsp_pkg::MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)),
                   $urandom(), pos);
      end
   endtask

   task automatic test_edge_cases();
      send_item(lsp_pkg::MODE_POP, '0, '0);
      send_item(lsp_pkg::MODE_TOP, '0, '0);
      send_item(lsp_pkg::MODE_BOTTOM, '0, '0);
      send_item(lsp_pkg::MODE_PEEK, '0, lsp_pkg::POS_W'(1));
      send_item(lsp_pkg::MODE_PEEK, '0, '0);
      for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) begin
         send_item(lsp_pkg::MODE_W'(m), WORD_ALL_ONES, '1);
      end
      send_item(lsp_pkg::MODE_PUSH, WORD_MIN, '0);
      send_item(lsp_pkg::MODE_PUSH, WORD_MAX, '1);
      send_item(lsp_pkg::MODE_PUSH, WORD_ALL_ONES, '0);
      send_item(lsp_pkg::MODE_PUSH, '0, '0);
      send_item(lsp_pkg::MODE_TOP, '0, '0);
      send_item(lsp_pkg::MODE_BOTTOM, '0, '0);
      send_item(lsp_pkg::MODE_PEEK, '0, lsp_pkg::POS_W'(1));
      send_item(lsp_pkg::MODE_PEEK, '0, lsp_pkg::POS_W'(4));
      send_item(lsp_pkg::MODE_PEEK, '0, lsp_pkg::POS_W'(5));
      send_item(lsp_pkg::MODE_PEEK, '0, '1);
      repeat (5) send_item(lsp_pkg::MODE_POP, '0, '0);
   endtask

   task automatic test_capacity_limits();
      write_capacity(lsp_pkg::PDATA_W'(1));
      send_item(lsp_pkg::MODE_PUSH, $urandom(), '0);
      send_item(lsp_pkg::MODE_PUSH, $urandom(), '0);
      send_item(lsp_pkg::MODE_PEEK, '0, lsp_pkg::POS_W'(1));
      send_item(lsp_pkg::MODE_POP, '0, '0);
      write_capacity('0);
      send_item(lsp_pkg::MODE_PUSH, $urandom(), '0);
      send_item(lsp_pkg::MODE_PUSH, $urandom(), '0);
      send_item(lsp_pkg::MODE_POP, '0, '0);
      write_capacity('1);
      repeat (lsp_pkg::DEPTH + 1) send_item(lsp_pkg::MODE_PUSH, $urandom(), '0);
      send_item(lsp_pkg::MODE_PEEK, '0, lsp_pkg::POS_W'(lsp_pkg::DEPTH));
      send_item(lsp_pkg::MODE_PEEK, '0, lsp_pkg::POS_W'(lsp_pkg::DEPTH + 1));
      write_capacity(lsp_pkg::PDATA_W'(3));
      send_item(lsp_pkg::MODE_PUSH, $urandom(), '0);
      send_item(lsp_pkg::MODE_TOP, '0, '0);
      send_item(lsp_pkg::MODE_BOTTOM, '0, '0);
      repeat (2) send_item(lsp_pkg::MODE_POP, '0, '0);
      write_capacity(lsp_pkg::PDATA_W'(lsp_pkg::DEPTH));
   endtask

   task automatic test_backpressure();
      wait_for_results();
      hold_requests++;
      repeat (30) send_random_item(45);
      wait_for_results();
   endtask

   task automatic test_random_phases();
      int caps [7];
      caps = '{16, 5, 1, 0, 31, 9, 16};
      for (int p = 0; p < 7; p++) begin
         write_capacity(lsp_pkg::PDATA_W'(caps[p]));
         sender_gaps   = (p != 2);
         receiver_gaps = (p != 3);
         repeat (40) send_random_item(55);
         repeat (20) send_random_item(10);
      end
   endtask

   task automatic test_back_to_back();
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      repeat (60) send_random_item(35);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = lsp_pkg::MODE_PUSH;
      req_push_value = '0;
      req_position   = '0;
      rsp_ready      = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      stack_fill     = 0;
      cap_setting    = lsp_pkg::CAP_RESET;
      mismatches     = 0;
      sender_gaps    = 1'b1;
      receiver_gaps  = 1'b1;
      hold_requests  = 0;
      hold_seen      = 0;
      hold_left      = 0;
      stall_left     = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_cases();
      test_capacity_limits();
      test_backpressure();
      test_random_phases();
      test_back_to_back();
      wait_for_results();
      repeat (5) @(posedge clock);
      if (pending_results.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      end
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout at %0t", $realtime);
      $display("== FAIL ==");
      $finish;
   end

endmodule
